// ===== rtl/aabb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pkg
// shared widths, constants and controller/datapath handshake types
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int INDEX_W = 3;
  localparam int LAYER_W = 4;
  localparam int COORD_W = 16;
  localparam int EXTENT_W = 15;

  localparam logic [LAYER_W-1:0] LAYER_NONE = '0;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_SCAN = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;       // store the input beat into its slot
    logic pair_valid;  // a pair address is issued this cycle
    logic done_tok;    // end-of-scan token enters the pipeline
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic done_out;    // done marker is on the result ports
  } stat_t;

endpackage

// ===== rtl/aabb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_ctrl
// scan sequencer: walks source/destination slot pairs and tracks busy
// ----------------------------------------------------------------------------
module aabb_ctrl import aabb_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          action,
  input  stat_t                         stat,
  output logic                          busy,
  output cmd_t                          cmd,
  output logic [$clog2(SLOT_COUNT)-1:0] src_idx,
  output logic [$clog2(SLOT_COUNT)-1:0] dst_idx
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic             accept;
  logic             last_pair;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign last_pair = (src_idx == IDX_LAST) && (dst_idx == IDX_LAST);

  assign cmd.wr_en      = accept && (action == ACTION_WRITE);
  assign cmd.pair_valid = (state == ST_SCAN);
  assign cmd.done_tok   = (state == ST_DONE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (action == ACTION_SCAN)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_pair) state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.done_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      src_idx <= '0;
      dst_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        if (dst_idx == IDX_LAST) begin
          dst_idx <= '0;
          src_idx <= (src_idx == IDX_LAST) ? '0 : src_idx + 1'b1;
        end else begin
          dst_idx <= dst_idx + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/aabb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_datapath
// slot store, pair filter, overlap test and result register
// ----------------------------------------------------------------------------
module aabb_datapath import aabb_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  input  logic [$clog2(SLOT_COUNT)-1:0] src_idx,
  input  logic [$clog2(SLOT_COUNT)-1:0] dst_idx,
  input  logic [INDEX_W-1:0]            box_index,
  input  logic                          box_enabled,
  input  logic                          has_handler,
  input  logic [LAYER_W-1:0]            source_layer,
  input  logic [LAYER_W-1:0]            target_layer,
  input  logic signed [COORD_W-1:0]     centre_x,
  input  logic signed [COORD_W-1:0]     centre_y,
  input  logic [EXTENT_W-1:0]           extent_x,
  input  logic [EXTENT_W-1:0]           extent_y,
  output stat_t                         stat,
  output logic                          strobe,
  output logic                          hit_valid,
  output logic [INDEX_W-1:0]            hit_target,
  output logic [INDEX_W-1:0]            hit_source,
  output logic                          last
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int ATTR_W = 1 + 2 * LAYER_W;
  localparam int GEOM_W = 2 * COORD_W + 2 * EXTENT_W;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SUM_W = EXTENT_W + 1;

  // slot memories: attributes and geometry, enabled bits in flops
  logic [ATTR_W-1:0] attr_mem [SLOT_COUNT];
  logic [GEOM_W-1:0] geom_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] enabled;

  logic              wr_ok;
  logic [IDX_W-1:0]  wr_addr;

  // stage 1: registered read data
  logic              p1_valid;
  logic              p1_done;
  logic [IDX_W-1:0]  p1_s;
  logic [IDX_W-1:0]  p1_d;
  logic              p1_s_en;
  logic              p1_d_en;
  logic [ATTR_W-1:0] p1_s_attr;
  logic [ATTR_W-1:0] p1_d_attr;
  logic [GEOM_W-1:0] p1_s_geom;
  logic [GEOM_W-1:0] p1_d_geom;

  logic               s_handler_unused;
  logic [LAYER_W-1:0] s_tgt;
  logic [LAYER_W-1:0] s_src_unused;
  logic               d_handler;
  logic [LAYER_W-1:0] d_src;
  logic [LAYER_W-1:0] d_tgt_unused;
  logic [COORD_W-1:0] s_cx, s_cy, d_cx, d_cy;
  logic [EXTENT_W-1:0] s_ex, s_ey, d_ex, d_ey;
  logic               qualify;

  // stage 2: centre difference and extent sum per axis
  logic              p2_q;
  logic              p2_done;
  logic [IDX_W-1:0]  p2_s;
  logic [IDX_W-1:0]  p2_d;
  logic [DIFF_W-1:0] p2_dx, p2_dy;
  logic [SUM_W-1:0]  p2_sx, p2_sy;

  logic [DIFF_W-1:0]  neg_x, neg_y;
  logic [COORD_W-1:0] abs_x, abs_y;
  logic               ovl_x, ovl_y;
  logic               hit;

  assign wr_ok   = cmd.wr_en && ({1'b0, box_index} < (INDEX_W + 1)'(SLOT_COUNT));
  assign wr_addr = box_index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= '0;
    end else if (wr_ok) begin
      enabled[wr_addr] <= box_enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      attr_mem[wr_addr] <= {has_handler, source_layer, target_layer};
      geom_mem[wr_addr] <= {centre_x, centre_y, extent_x, extent_y};
    end
    p1_s_attr <= attr_mem[src_idx];
    p1_d_attr <= attr_mem[dst_idx];
    p1_s_geom <= geom_mem[src_idx];
    p1_d_geom <= geom_mem[dst_idx];
    p1_s_en   <= enabled[src_idx];
    p1_d_en   <= enabled[dst_idx];
    p1_s      <= src_idx;
    p1_d      <= dst_idx;
  end

  assign {s_handler_unused, s_src_unused, s_tgt} = p1_s_attr;
  assign {d_handler, d_src, d_tgt_unused}        = p1_d_attr;
  assign {s_cx, s_cy, s_ex, s_ey} = p1_s_geom;
  assign {d_cx, d_cy, d_ex, d_ey} = p1_d_geom;

  // layer, enable, self and handler filter
  assign qualify = p1_valid && p1_s_en && (s_tgt != LAYER_NONE) && p1_d_en &&
                   (p1_s != p1_d) && (d_src == s_tgt) && d_handler;

  always_ff @(posedge clk) begin
    p2_s  <= p1_s;
    p2_d  <= p1_d;
    p2_dx <= {d_cx[COORD_W-1], d_cx} - {s_cx[COORD_W-1], s_cx};
    p2_dy <= {d_cy[COORD_W-1], d_cy} - {s_cy[COORD_W-1], s_cy};
    p2_sx <= {1'b0, d_ex} + {1'b0, s_ex};
    p2_sy <= {1'b0, d_ey} + {1'b0, s_ey};
  end

  // touching boxes overlap: 2*|dc| <= ed + es on doubled coordinates
  assign neg_x = DIFF_W'(0) - p2_dx;
  assign neg_y = DIFF_W'(0) - p2_dy;
  assign abs_x = p2_dx[DIFF_W-1] ? neg_x[COORD_W-1:0] : p2_dx[COORD_W-1:0];
  assign abs_y = p2_dy[DIFF_W-1] ? neg_y[COORD_W-1:0] : p2_dy[COORD_W-1:0];
  assign ovl_x = ({abs_x, 1'b0} <= {1'b0, p2_sx});
  assign ovl_y = ({abs_y, 1'b0} <= {1'b0, p2_sy});
  assign hit   = p2_q && ovl_x && ovl_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p1_done   <= 1'b0;
      p2_q      <= 1'b0;
      p2_done   <= 1'b0;
      strobe    <= 1'b0;
      hit_valid <= 1'b0;
      last      <= 1'b0;
    end else begin
      p1_valid  <= cmd.pair_valid;
      p1_done   <= cmd.done_tok;
      p2_q      <= qualify;
      p2_done   <= p1_done;
      strobe    <= hit || p2_done;
      hit_valid <= hit;
      last      <= p2_done;
    end
  end

  always_ff @(posedge clk) begin
    hit_target <= hit ? INDEX_W'(p2_d) : '0;
    hit_source <= hit ? INDEX_W'(p2_s) : '0;
  end

  assign stat.done_out = strobe && last;

endmodule

// ===== rtl/aabb_pair_collision_scan_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pair_collision_scan_core
// layer-filtered box overlap scanner over a small table of box slots
// ----------------------------------------------------------------------------
// a beat is taken when start is high and busy is low. a write beat
// (action 0) stores one slot in that cycle and leaves busy low, so writes
// can follow each other every cycle; a write to an index at or beyond
// SLOT_COUNT is dropped. a scan beat (action 1) raises busy until its
// done marker is on the result ports: the sequencer issues one ordered
// pair per cycle into a three-stage pipeline (slot read,
// centre difference and extent sum, overlap compare into the result
// register), then one done token that leaves the pipeline behind the
// last pair. results come out on strobe, one per cycle at most, and must
// be taken in the cycle they show up, since nothing here can hold them.
// hits arrive in source-major, destination-minor slot order, followed by
// exactly one beat with hit_valid low and last high.
// ----------------------------------------------------------------------------
module aabb_pair_collision_scan_core import aabb_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  // command side
  input  logic                      start,
  output logic                      busy,
  input  logic                      action,
  input  logic [INDEX_W-1:0]        box_index,
  input  logic                      box_enabled,
  input  logic                      has_handler,
  input  logic [LAYER_W-1:0]        source_layer,
  input  logic [LAYER_W-1:0]        target_layer,
  input  logic signed [COORD_W-1:0] centre_x,
  input  logic signed [COORD_W-1:0] centre_y,
  input  logic [EXTENT_W-1:0]       extent_x,
  input  logic [EXTENT_W-1:0]       extent_y,
  // result side
  output logic                      strobe,
  output logic                      hit_valid,
  output logic [INDEX_W-1:0]        hit_target,
  output logic [INDEX_W-1:0]        hit_source,
  output logic                      last
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  cmd_t             cmd;
  stat_t            stat;
  logic [IDX_W-1:0] src_idx;
  logic [IDX_W-1:0] dst_idx;

  // sequencer: pair counters and busy
  aabb_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .action  (action),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd),
    .src_idx (src_idx),
    .dst_idx (dst_idx)
  );

  // slot store, filter and overlap pipeline
  aabb_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .src_idx      (src_idx),
    .dst_idx      (dst_idx),
    .box_index    (box_index),
    .box_enabled  (box_enabled),
    .has_handler  (has_handler),
    .source_layer (source_layer),
    .target_layer (target_layer),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .extent_x     (extent_x),
    .extent_y     (extent_y),
    .stat         (stat),
    .strobe       (strobe),
    .hit_valid    (hit_valid),
    .hit_target   (hit_target),
    .hit_source   (hit_source),
    .last         (last)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the box pair collision scanner: beats are driven
// on the command port and mirrored into a slot table kept here. each scan
// beat is expanded into the hits it must report plus the closing done
// marker, and every strobed result is compared in order against that list.
// directed cases come first, then randomized slot traffic.
// ----------------------------------------------------------------------------
module tb_top;
  import aabb_pkg::*;

  localparam int SLOT_COUNT = 8;
  localparam int RANDOM_BEATS = 85;

  // one command beat, also used as the stored form of a slot
  typedef struct packed {
    logic                      action;
    logic [INDEX_W-1:0]        index;
    logic                      enabled;
    logic                      handler;
    logic [LAYER_W-1:0]        src_layer;
    logic [LAYER_W-1:0]        tgt_layer;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [EXTENT_W-1:0]       ex;
    logic [EXTENT_W-1:0]       ey;
  } box_beat_t;

  localparam int BEAT_W = $bits(box_beat_t);

  // one result beat
  typedef struct packed {
    logic               hit_valid;
    logic [INDEX_W-1:0] target;
    logic [INDEX_W-1:0] source;
    logic               last;
  } hit_report_t;

  logic        clk;
  logic        rst;
  logic        start;
  box_beat_t   drv;
  logic        busy;
  logic        strobe;
  logic        hit_valid;
  logic [INDEX_W-1:0] hit_target;
  logic [INDEX_W-1:0] hit_source;
  logic        last;

  // slot table mirror and the hits still owed by the block
  box_beat_t   model_slots [SLOT_COUNT];
  hit_report_t pending_hits [$];
  int          fail_count;
  // when set, the sender issues beats back to back
  bit          back_to_back;

  aabb_pair_collision_scan_core #(
    .SLOT_COUNT(SLOT_COUNT)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (drv.action),
    .box_index   (drv.index),
    .box_enabled (drv.enabled),
    .has_handler (drv.handler),
    .source_layer(drv.src_layer),
    .target_layer(drv.tgt_layer),
    .centre_x    (drv.cx),
    .centre_y    (drv.cy),
    .extent_x    (drv.ex),
    .extent_y    (drv.ey),
    .strobe      (strobe),
    .hit_valid   (hit_valid),
    .hit_target  (hit_target),
    .hit_source  (hit_source),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // exact one-axis overlap on doubled coordinates; touching counts
  function automatic bit spans_meet(input logic signed [COORD_W-1:0] cd,
                                    input logic [EXTENT_W-1:0] ed,
                                    input logic signed [COORD_W-1:0] cs,
                                    input logic [EXTENT_W-1:0] es);
    longint hi_d, hi_s, lo_d, lo_s, hi, lo;
    hi_d = 2 * longint'(cd) + longint'(ed);
    hi_s = 2 * longint'(cs) + longint'(es);
    lo_d = 2 * longint'(cd) - longint'(ed);
    lo_s = 2 * longint'(cs) - longint'(es);
    hi = (hi_d > hi_s) ? hi_d : hi_s;
    lo = (lo_d < lo_s) ? lo_d : lo_s;
    return (hi - lo) <= 2 * (longint'(ed) + longint'(es));
  endfunction

  // apply one accepted beat: store a slot, or list the hits of a scan
  task automatic collision_scan_predict(input box_beat_t b);
    hit_report_t r;
    box_beat_t   src;
    box_beat_t   dst;
    if (b.action == ACTION_WRITE) begin
      // slot index past the table is dropped
      if (int'(b.index) < SLOT_COUNT) model_slots[b.index] = b;
      return;
    end
    // source outer, destination inner, in slot order
    for (int s = 0; s < SLOT_COUNT; s++) begin
      src = model_slots[s];
      if (!src.enabled || src.tgt_layer == LAYER_NONE) continue;
      for (int d = 0; d < SLOT_COUNT; d++) begin
        dst = model_slots[d];
        // never its own destination, and layers must line up
        if (!dst.enabled || d == s || dst.src_layer != src.tgt_layer) continue;
        if (spans_meet(dst.cx, dst.ex, src.cx, src.ex) &&
            spans_meet(dst.cy, dst.ey, src.cy, src.ey) && dst.handler) begin
          r.hit_valid = 1'b1;
          r.target    = INDEX_W'(d);
          r.source    = INDEX_W'(s);
          r.last      = 1'b0;
          pending_hits.insert(pending_hits.size(), r);
        end
      end
    end
    // every scan closes with the done marker, even an empty one
    r = '0;
    r.last = 1'b1;
    pending_hits.insert(pending_hits.size(), r);
  endtask

  // command side monitor: a beat counts when start is high and busy low
  always @(posedge clk) begin
    if (!rst && start && !busy) collision_scan_predict(drv);
  end

  // result side checker: strobed beats are compared against the oldest entry
  always @(posedge clk) begin
    hit_report_t want;
    if (!rst && strobe === 1'b1) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected result beat: hit_valid %0d target %0d source %0d last %0d",
               hit_valid, hit_target, hit_source, last);
        fail_count++;
      end else begin
        want = pending_hits.pop_front();
        if (hit_valid !== want.hit_valid) begin
          $error("hit_valid mismatch: expected %0d, got %0d", want.hit_valid, hit_valid);
          fail_count++;
        end
        if (hit_target !== want.target) begin
          $error("hit_target mismatch: expected %0d, got %0d", want.target, hit_target);
          fail_count++;
        end
        if (hit_source !== want.source) begin
          $error("hit_source mismatch: expected %0d, got %0d", want.source, hit_source);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, last);
          fail_count++;
        end
      end
    end
  end

  // idle length after a beat: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    if (back_to_back) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one beat, hold it until taken, then idle a while
  task automatic send_beat(input box_beat_t b);
    int gap;
    gap = pick_gap();
    drv   <= b;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_box(input int idx, input bit en, input bit hnd,
                           input int sl, input int tl, input int cx, input int cy,
                           input int ex, input int ey);
    box_beat_t b;
    b.action    = ACTION_WRITE;
    b.index     = INDEX_W'(idx);
    b.enabled   = en;
    b.handler   = hnd;
    b.src_layer = LAYER_W'(sl);
    b.tgt_layer = LAYER_W'(tl);
    b.cx        = COORD_W'(cx);
    b.cy        = COORD_W'(cy);
    b.ex        = EXTENT_W'(ex);
    b.ey        = EXTENT_W'(ey);
    send_beat(b);
  endtask

  // scan beat; the slot fields ride along with random content
  task automatic scan_all();
    box_beat_t b;
    b = BEAT_W'({$urandom, $urandom, $urandom});
    b.action = ACTION_SCAN;
    send_beat(b);
  endtask

  // hold the sender until everything owed has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  // table still empty after reset: only the done marker
  task automatic test_empty_scan();
    scan_all();
  endtask

  // boxes that touch on one edge hit both ways, one step apart they miss
  task automatic test_touching_edges();
    write_box(0, 1, 1, 1, 2, 0, 0, 32, 32);
    write_box(1, 1, 1, 2, 1, 32, 0, 32, 32);
    scan_all();
    write_box(1, 1, 1, 2, 1, 33, 0, 32, 32);
    scan_all();
    // touching along y instead
    write_box(1, 1, 1, 2, 1, 0, -32, 32, 32);
  endtask

  // corner coordinates, full and zero extents, top layer number
  task automatic test_coordinate_extremes();
    write_box(2, 1, 1, 15, 15, -32768, 32767, 32767, 0);
    write_box(3, 1, 1, 15, 15, 32767, -32768, 0, 32767);
    // a point sitting on the flat edge of slot 2
    write_box(4, 1, 1, 15, 15, -32768, 32767, 0, 0);
    scan_all();
  endtask

  // source without target, destination without handler, self pair,
  // and a slot cleared by a disabled write
  task automatic test_pair_filters();
    write_box(5, 1, 1, 6, 0, 0, 0, 100, 100);
    write_box(6, 1, 0, 6, 6, 0, 0, 100, 100);
    write_box(7, 1, 1, 9, 6, 10, -10, 100, 100);
    scan_all();
    write_box(7, 0, 1, 6, 6, 0, 0, 100, 100);
    scan_all();
  endtask

  // every slot on top of every other: the most hits a scan can report
  task automatic test_all_slots_hit();
    for (int i = 0; i < SLOT_COUNT; i++) write_box(i, 1, 1, 3, 3, -5, 7, 64, 48);
    scan_all();
  endtask

  function automatic logic [COORD_W-1:0] pick_centre();
    if ($urandom_range(0, 9) < 7) return COORD_W'($urandom_range(0, 511)) - COORD_W'(256);
    return COORD_W'($urandom);
  endfunction

  function automatic logic [EXTENT_W-1:0] pick_extent();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return EXTENT_W'($urandom_range(0, 512));
    if (roll < 9) return EXTENT_W'($urandom);
    return $urandom_range(0, 1) ? '1 : '0;
  endfunction

  function automatic logic [LAYER_W-1:0] pick_layer();
    // a few layers so that pairs line up often
    if ($urandom_range(0, 9) < 8) return LAYER_W'($urandom_range(0, 3));
    return LAYER_W'($urandom);
  endfunction

  // mostly slot writes clustered near the origin, with a scan now and then
  task automatic test_random_traffic();
    box_beat_t b;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      back_to_back = (n >= 30 && n < 50);
      if (n == 60) wait_drained();
      if ($urandom_range(0, 4) == 0) begin
        scan_all();
      end else begin
        b.action    = ACTION_WRITE;
        b.index     = INDEX_W'($urandom);
        b.enabled   = ($urandom_range(0, 9) != 0);
        b.handler   = ($urandom_range(0, 5) != 0);
        b.src_layer = pick_layer();
        b.tgt_layer = pick_layer();
        b.cx        = pick_centre();
        b.cy        = pick_centre();
        b.ex        = pick_extent();
        b.ey        = pick_extent();
        send_beat(b);
      end
    end
    back_to_back = 1'b0;
    scan_all();
  endtask

  initial begin
    int waited;
    rst          = 1'b1;
    start        = 1'b0;
    drv          = '0;
    fail_count   = 0;
    back_to_back = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) model_slots[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_scan();
    test_touching_edges();
    test_coordinate_extremes();
    test_pair_filters();
    test_all_slots_hit();
    test_random_traffic();

    start <= 1'b0;
    // drain, then idle a while longer to catch stray beats
    waited = 0;
    while (pending_hits.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SLOT_COUNT * SLOT_COUNT + 8) @(posedge clk);
    if (pending_hits.size() != 0) begin
      $error("%0d result beats never arrived", pending_hits.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aabb_pkg.sv
rtl/aabb_ctrl.sv
rtl/aabb_datapath.sv
rtl/aabb_pair_collision_scan_core.sv
tb/tb_top.sv
